// ===== rtl/tbdc_pkg.sv =====
`default_nettype none

package tbdc_pkg;

    // data widths
    localparam int LEVEL_BITS = 12;
    localparam int ERR_BITS   = LEVEL_BITS + 1;
    localparam int SCALED_W   = LEVEL_BITS + 7;
    localparam int DUTY_BITS  = 7;

    // trend codes
    localparam logic [1:0] TREND_DIST   = 2'd0;
    localparam logic [1:0] TREND_FALL   = 2'd1;
    localparam logic [1:0] TREND_STEADY = 2'd2;
    localparam logic [1:0] TREND_RISE   = 2'd3;

    // band codes
    localparam logic [1:0] BAND_NONE = 2'd0;
    localparam logic [1:0] BAND_LOW  = 2'd1;
    localparam logic [1:0] BAND_MID  = 2'd2;
    localparam logic [1:0] BAND_HIGH = 2'd3;

    // band thresholds, percent of reference
    localparam logic [6:0] PCT_SCALE = 7'd100;
    localparam logic [6:0] PCT_LOW   = 7'd60;
    localparam logic [6:0] PCT_MID   = 7'd80;

    // duty limits per band
    localparam logic [DUTY_BITS-1:0] LOW_MIN  = 7'd70;
    localparam logic [DUTY_BITS-1:0] LOW_MAX  = 7'd100;
    localparam logic [DUTY_BITS-1:0] MID_MIN  = 7'd60;
    localparam logic [DUTY_BITS-1:0] MID_MAX  = 7'd80;
    localparam logic [DUTY_BITS-1:0] HIGH_MIN = 7'd50;
    localparam logic [DUTY_BITS-1:0] HIGH_MAX = 7'd70;

    // duty steps
    localparam logic [DUTY_BITS-1:0] STEP_FALL = 7'd5;
    localparam logic [DUTY_BITS-1:0] STEP_RISE = 7'd10;

    // loop state carried between requests
    typedef struct packed {
        logic signed [ERR_BITS-1:0] err_now;
        logic signed [ERR_BITS-1:0] err_prev;
        logic signed [ERR_BITS-1:0] err_older;
        logic [DUTY_BITS-1:0]       duty;
        logic [1:0]                 band;
    } t_state;

    // one result request
    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_percent;
        logic [1:0]           band;
        logic [1:0]           trend;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/tbdc_ifs.sv =====
`default_nettype none

// level sample channel
interface tbdc_level_if;
    logic                             valid;
    logic                             ready;
    logic [tbdc_pkg::LEVEL_BITS-1:0]  level_ml;

    modport source (output valid, output level_ml, input ready);
    modport sink   (input valid, input level_ml, output ready);
endinterface

// duty result channel
interface tbdc_result_if;
    logic                             valid;
    logic                             ready;
    logic [tbdc_pkg::DUTY_BITS-1:0]   duty_percent;
    logic [1:0]                       band;
    logic [1:0]                       trend;

    modport source (output valid, output duty_percent, output band, output trend,
                    input ready);
    modport sink   (input valid, input duty_percent, input band, input trend,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/tbdc_step.sv =====
`default_nettype none

// One control step: error history, trend, band pick and duty update.
module tbdc_step (
    input  wire logic [tbdc_pkg::LEVEL_BITS-1:0] i_level,
    input  wire logic [tbdc_pkg::LEVEL_BITS-1:0] i_reference,
    input  wire tbdc_pkg::t_state                i_state,
    output tbdc_pkg::t_state                     o_state,
    output tbdc_pkg::t_result                    o_result
);
    import tbdc_pkg::*;

    logic signed [ERR_BITS-1:0] err;
    logic                       err_pos;
    logic [1:0]                 trend;
    logic [SCALED_W-1:0]        scaled;
    logic [SCALED_W-1:0]        ref_low;
    logic [SCALED_W-1:0]        ref_mid;
    logic [1:0]                 band;
    logic [DUTY_BITS-1:0]       lo;
    logic [DUTY_BITS-1:0]       hi;
    logic [DUTY_BITS-1:0]       duty_step;
    logic [DUTY_BITS-1:0]       duty_clamp;

    // new error, zero-extended operands
    assign err = $signed({1'b0, i_reference}) - $signed({1'b0, i_level});
    assign err_pos = !err[ERR_BITS-1] && (err != '0);

    // trend over prev, now and the new error
    always_comb begin
        if (i_state.err_prev > i_state.err_now && i_state.err_now > err) begin
            trend = TREND_FALL;
        end else if (i_state.err_prev == i_state.err_now && i_state.err_now == err) begin
            trend = TREND_STEADY;
        end else if (i_state.err_prev < i_state.err_now && i_state.err_now < err) begin
            trend = TREND_RISE;
        end else begin
            trend = TREND_DIST;
        end
    end

    // band pick by scaled compare, no division
    assign scaled  = SCALED_W'(i_level) * SCALED_W'(PCT_SCALE);
    assign ref_low = SCALED_W'(i_reference) * SCALED_W'(PCT_LOW);
    assign ref_mid = SCALED_W'(i_reference) * SCALED_W'(PCT_MID);

    always_comb begin
        if (scaled <= ref_low) begin
            band = BAND_LOW;  lo = LOW_MIN;  hi = LOW_MAX;
        end else if (scaled < ref_mid) begin
            band = BAND_MID;  lo = MID_MIN;  hi = MID_MAX;
        end else begin
            band = BAND_HIGH; lo = HIGH_MIN; hi = HIGH_MAX;
        end
    end

    // duty move, max 100 + 10 fits the duty width
    always_comb begin
        duty_step = i_state.duty;
        if (trend != TREND_DIST) begin
            if (band != i_state.band) begin
                duty_step = lo;
            end else if (trend == TREND_FALL) begin
                duty_step = i_state.duty + STEP_FALL;
            end else if (trend == TREND_RISE) begin
                duty_step = i_state.duty + STEP_RISE;
            end
        end
        duty_clamp = duty_step;
        if (duty_clamp > hi) begin
            duty_clamp = hi;
        end
        if (duty_clamp < lo) begin
            duty_clamp = lo;
        end
    end

    // next state and result
    always_comb begin
        o_state.err_older = i_state.err_prev;
        o_state.err_prev  = i_state.err_now;
        o_state.err_now   = err;
        if (err_pos) begin
            o_state.duty    = duty_clamp;
            o_state.band    = band;
            o_result.trend  = trend;
        end else begin
            o_state.duty    = '0;
            o_state.band    = i_state.band;
            o_result.trend  = TREND_DIST;
        end
        o_result.duty_percent = o_state.duty;
        o_result.band         = o_state.band;
    end

endmodule

`default_nettype wire

// ===== rtl/trend_banded_duty_controller.sv =====
// An accepted level request waits in the input register until the result register
// can take it. Throughput: one request per cycle while results are not stalled; the
// control step is combinational between the registers, with state updated in it.
// Reset (i_rst_n low, synchronous): clears reference, error history, duty,
// band and both valid flags.
`default_nettype none

module trend_banded_duty_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tbdc_pkg::LEVEL_BITS-1:0] i_cfg_wdata,
    tbdc_level_if.sink                           i_level,
    tbdc_result_if.source                        o_result
);
    import tbdc_pkg::*;

    logic                  r_in_valid;
    logic [LEVEL_BITS-1:0] r_level;
    logic [LEVEL_BITS-1:0] r_reference;
    t_state                r_state;
    t_state                n_state;
    logic                  r_out_valid;
    t_result               r_result;
    t_result               n_result;
    logic                  advance;

    // flow control: the step runs when the result register can take it
    assign advance       = !r_out_valid || o_result.ready;
    assign i_level.ready = !r_in_valid || advance;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference <= '0;
        end else if (i_cfg_we) begin
            r_reference <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_level.ready) begin
            r_in_valid <= i_level.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_level.valid && i_level.ready) begin
            r_level <= i_level.level_ml;
        end
    end

    tbdc_step u_step (
        .i_level     (r_level),
        .i_reference (r_reference),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // loop state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.duty_percent = r_result.duty_percent;
    assign o_result.band         = r_result.band;
    assign o_result.trend        = r_result.trend;

endmodule

`default_nettype wire
